// ===== hw/rtl/efc_pkg.sv =====
// Package for the fly camera core: fixed-point constants, types and the shared
// state-machine codes. No dependencies.
package efc_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int VEC_FRAC_BITS   = 14;
  localparam int POS_FRAC_BITS   = 16;

  localparam logic [15:0] YAW_RESET   = 16'(270 << ANGLE_FRAC_BITS);
  localparam logic [15:0] FULL_TURN   = 16'(360 << ANGLE_FRAC_BITS);
  localparam logic [15:0] QUARTER     = 16'(90 << ANGLE_FRAC_BITS);
  localparam logic [14:0] PITCH_LIM   = 15'(89 << ANGLE_FRAC_BITS);
  localparam logic [15:0] SPEED_RESET = 16'd640;
  localparam logic [31:0] DEG_Q32     = 32'd74961321;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam int          MOVE_SHIFT  = 24 + VEC_FRAC_BITS - POS_FRAC_BITS;
  localparam int          VEC_SHIFT   = 30 - VEC_FRAC_BITS;

  localparam logic        OP_TURN = 1'b0;
  localparam logic        OP_MOVE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_SC_YAW, ST_SC_PITCH, ST_BASIS,
    ST_MOVE, ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  // Taylor divisors: sine steps (2k)(2k+1), cosine steps (2k-1)(2k)
  function automatic logic [7:0] taylor_div(input logic cosine, input logic [2:0] k);
    logic [7:0] d;
    d = 8'd1;
    if (cosine) begin
      case (k)
        3'd1: d = 8'd2;   3'd2: d = 8'd12;  3'd3: d = 8'd30;  3'd4: d = 8'd56;
        3'd5: d = 8'd90;  3'd6: d = 8'd132; 3'd7: d = 8'd182;
        default: d = 8'd1;
      endcase
    end else begin
      case (k)
        3'd1: d = 8'd6;   3'd2: d = 8'd20;  3'd3: d = 8'd42;  3'd4: d = 8'd72;
        3'd5: d = 8'd110; 3'd6: d = 8'd156;
        default: d = 8'd1;
      endcase
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/efc_serial_mul.sv =====
// Bit-serial 32x32 unsigned multiplier: one multiplier bit per cycle.
// Depends on efc_pkg.
module efc_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  efc_pkg::mul_req_t req,
  output efc_pkg::mul_rsp_t rsp
);
  import efc_pkg::*;

  logic [31:0] mcand;
  logic [31:0] mplier;
  logic [63:0] acc;
  logic [5:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy   <= 1'b1;
      cnt    <= 6'd32;
      mcand  <= req.a;
      mplier <= req.b;
      acc    <= '0;
    end else if (busy) begin
      // add the partial product on the top, shift the whole word right
      acc    <= {(mplier[0] ? {1'b0, acc[63:32]} + {1'b0, mcand}
                            : {1'b0, acc[63:32]}), acc[31:1]};
      mplier <= mplier >> 1;
      cnt    <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign rsp.done = busy && (cnt == 6'd1) && !req.start;
  assign rsp.prod = {(mplier[0] ? {1'b0, acc[63:32]} + {1'b0, mcand}
                                : {1'b0, acc[63:32]}), acc[31:1]};
endmodule

// ===== hw/rtl/efc_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 8-bit divisor.
// Depends on efc_pkg.
module efc_serial_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import efc_pkg::*;

  logic [31:0] quo;
  logic [8:0]  rem;
  logic [7:0]  dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [8:0]  trial;
  logic [9:0]  diff;

  assign trial = {rem[7:0], quo[31]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (!diff[9]) begin
        rem <= diff[8:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assign done     = busy && (cnt == 6'd1) && !start;
  assign quotient = {quo[30:0], !diff[9]};
endmodule

// ===== hw/rtl/euler_fly_camera_update_core.sv =====
// Fly camera update core: angle state, sine/cosine series and move stepping
// around a shared bit-serial multiplier and divider. Depends on efc_pkg,
// efc_serial_mul and efc_serial_div.
//
// Usage: in_valid/in_stall take one transfer of operation, deltas, move_dir and
// frame_time. A turn adds the deltas (yaw wrapped to a full circle, pitch held
// within plus or minus 89 degrees) and rebuilds front, right and up from sine
// and cosine. A move steps the position along a signed basis vector by
// move_speed * frame_time with saturation. Every transfer returns one result
// on out_valid/out_stall: position and the three basis vectors.
// Each multiply is issued to the shared bit-serial multiplier; a Taylor
// division follows its multiply directly in the serial divider. A turn runs
// x, x^2, six sine and seven cosine terms for yaw and again for pitch, then
// four basis products before out_valid. A move runs the speed product and
// three component products, a move with no direction only the speed product.
// One item at a time: the next input transfer can come in the cycle after
// the result transfer.
// Reset (rst, synchronous) sets yaw to 270 degrees, pitch and position to zero,
// front (0,0,-1), right (1,0,0), up (0,1,0) and move_speed to 2.5.
// If the receiver stalls, the result is held and no new item is accepted
// until it has been taken. cfg_we writes move_speed; write only while idle.
module euler_fly_camera_update_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] yaw_delta,
  input  logic signed [15:0] pitch_delta,
  input  logic [2:0]         move_dir,
  input  logic [15:0]        frame_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] front_x,
  output logic signed [15:0] front_y,
  output logic signed [15:0] front_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);
  import efc_pkg::*;

  // architectural state
  logic [15:0]        move_speed;
  logic [15:0]        yaw_angle;
  logic signed [14:0] pitch_angle;
  logic signed [31:0] pos [3];
  logic signed [15:0] bv  [9];

  state_t state, state_next;

  // item registers
  logic [2:0]  dir;
  logic [15:0] ftime;
  logic        op;

  // series working registers (Q30 magnitudes)
  logic [31:0] xr, x2, term;
  logic signed [33:0] sum;
  logic [3:0]  step;      // micro step inside the series
  logic [2:0]  k;
  logic        cos_pass;  // computing the cosine series
  logic        pitch_pass;
  logic signed [33:0] sy, cy, sp, cp, s_res;
  logic        pneg;
  logic [3:0]  bidx;
  logic [1:0]  comp;
  logic [31:0] dmove;

  // shared units
  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     dstart, ddone;
  logic [31:0] dquo;
  logic [31:0] ddend;
  logic [7:0]  ddsr;

  efc_serial_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  efc_serial_div u_div (.clk(clk), .rst(rst), .start(dstart), .dividend(ddend),
                        .divisor(ddsr), .done(ddone), .quotient(dquo));

  // series step codes
  localparam logic [3:0] SS_X   = 4'd0;
  localparam logic [3:0] SS_XW  = 4'd1;
  localparam logic [3:0] SS_X2  = 4'd2;
  localparam logic [3:0] SS_X2W = 4'd3;
  localparam logic [3:0] SS_TM  = 4'd4;
  localparam logic [3:0] SS_TMW = 4'd5;
  localparam logic [3:0] SS_DVW = 4'd6;

  // rounding helpers
  function automatic logic [31:0] rnd30(input logic [63:0] p);
    logic [63:0] t;
    t = p + 64'(1 << 29);
    return t[61:30];
  endfunction

  function automatic logic signed [15:0] to_vec(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] r;
    m = v[33] ? -v : v;
    r = (m + 34'(1 << (VEC_SHIFT - 1))) >> VEC_SHIFT;
    return v[33] ? -r[15:0] : r[15:0];
  endfunction

  function automatic logic signed [33:0] clamp_unit(input logic signed [33:0] v);
    if (v < 0) return '0;
    if (v > $signed({2'b00, ONE_Q30})) return $signed({2'b00, ONE_Q30});
    return v;
  endfunction

  // yaw / pitch updates
  logic signed [17:0] ysum;
  logic signed [17:0] ywrap;
  logic signed [16:0] psum;
  logic signed [14:0] pclamp;
  assign ysum = $signed({2'b00, yaw_angle}) + 18'(yaw_delta);
  always_comb begin
    ywrap = ysum;
    if (ysum < 0) ywrap = ysum + $signed({2'b00, FULL_TURN});
    else if (ysum >= $signed({2'b00, FULL_TURN}))
      ywrap = ysum - $signed({2'b00, FULL_TURN});
    if (ywrap >= $signed({2'b00, FULL_TURN}))
      ywrap = ywrap - $signed({2'b00, FULL_TURN});
  end
  assign psum = 17'(pitch_angle) + 17'(pitch_delta);
  always_comb begin
    pclamp = psum[14:0];
    if (psum > $signed({2'b00, PITCH_LIM})) pclamp = PITCH_LIM;
    else if (psum < -$signed({2'b00, PITCH_LIM})) pclamp = -PITCH_LIM;
  end

  // quadrant split of yaw (at most three compares)
  logic [15:0] yaw_r;
  logic [1:0]  yaw_q;
  always_comb begin
    if (yaw_angle >= 16'(3 * QUARTER)) begin
      yaw_q = 2'd3; yaw_r = yaw_angle - 16'(3 * QUARTER);
    end else if (yaw_angle >= 16'(2 * QUARTER)) begin
      yaw_q = 2'd2; yaw_r = yaw_angle - 16'(2 * QUARTER);
    end else if (yaw_angle >= QUARTER) begin
      yaw_q = 2'd1; yaw_r = yaw_angle - QUARTER;
    end else begin
      yaw_q = 2'd0; yaw_r = yaw_angle;
    end
  end
  logic [14:0] pitch_mag;
  assign pitch_mag = pitch_angle[14] ? -pitch_angle : pitch_angle;

  // basis product operands for step bidx
  logic signed [33:0] opa, opb;
  always_comb begin
    case (bidx)
      4'd0:    begin opa = cy; opb = cp; end
      4'd1:    begin opa = sy; opb = cp; end
      4'd2:    begin opa = cy; opb = sp; end
      default: begin opa = sy; opb = sp; end
    endcase
  end

  // move operands
  logic signed [15:0] mv_comp;
  logic               mv_neg;
  logic [15:0]        mv_mag;
  always_comb begin
    case (dir[2:1])
      2'd0:    mv_comp = bv[2'(0) * 3 + comp];
      2'd1:    mv_comp = bv[3 + comp];
      default: mv_comp = bv[6 + comp];
    endcase
  end
  assign mv_neg = mv_comp[15] ^ (dir == 3'd1 || dir == 3'd2 || dir == 3'd5);
  assign mv_mag = mv_comp[15] ? -mv_comp : mv_comp;

  logic [63:0] mv_round;
  logic signed [33:0] mv_step;
  logic signed [34:0] mv_np;
  assign mv_round = (mrsp.prod + (64'(1) << (MOVE_SHIFT - 1))) >> MOVE_SHIFT;
  assign mv_step  = mv_neg ? -$signed({1'b0, mv_round[32:0]})
                           : $signed({1'b0, mv_round[32:0]});
  assign mv_np = 35'(pos[comp]) + 35'(mv_step);

  // last cosine term of a series has come back from the divider
  logic series_end;
  assign series_end = (step == SS_DVW) && ddone && cos_pass && (k == 3'd7);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid && !in_stall) state_next = ST_ANGLE;
      ST_ANGLE:    state_next = op ? ST_MOVE : ST_SC_YAW;
      ST_SC_YAW:   if (series_end) state_next = ST_SC_PITCH;
      ST_SC_PITCH: if (series_end) state_next = ST_BASIS;
      ST_BASIS:    if (step == SS_XW && mrsp.done && bidx == 4'd3) state_next = ST_DONE;
      ST_MOVE: begin
        if (mrsp.done && ((step == SS_XW && dir >= 3'd6) ||
                          (step == SS_X2W && comp == 2'd2)))
          state_next = ST_DONE;
      end
      ST_DONE:     if (!out_stall) state_next = ST_IDLE;
      default:     state_next = state;
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  always_comb begin
    pos_x = pos[0]; pos_y = pos[1]; pos_z = pos[2];
    front_x = bv[0]; front_y = bv[1]; front_z = bv[2];
    right_x = bv[3]; right_y = bv[4]; right_z = bv[5];
    up_x = bv[6]; up_y = bv[7]; up_z = bv[8];
  end

  always_ff @(posedge clk) begin
    mreq.start <= 1'b0;
    dstart     <= 1'b0;
    if (rst) begin
      state       <= ST_IDLE;
      move_speed  <= SPEED_RESET;
      yaw_angle   <= YAW_RESET;
      pitch_angle <= '0;
      for (int i = 0; i < 3; i++) pos[i] <= '0;
      for (int i = 0; i < 9; i++) bv[i] <= '0;
      bv[2] <= -16'(1 << VEC_FRAC_BITS);
      bv[3] <= 16'(1 << VEC_FRAC_BITS);
      bv[7] <= 16'(1 << VEC_FRAC_BITS);
      step <= SS_X;
    end else begin
      state <= state_next;
      if (cfg_we) move_speed <= cfg_wdata;
      case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          op <= operation; dir <= move_dir; ftime <= frame_time;
          if (operation == OP_TURN) begin
            yaw_angle   <= ywrap[15:0];
            pitch_angle <= pclamp;
          end
        end
        ST_ANGLE: begin
          step <= SS_X; pitch_pass <= 1'b0; comp <= '0; bidx <= '0;
          if (op == OP_MOVE) begin
            mreq.start <= 1'b1;
            mreq.a <= 32'(move_speed);
            mreq.b <= 32'(ftime);
            step   <= SS_XW;
          end
        end
        ST_SC_YAW, ST_SC_PITCH: begin
          case (step)
            SS_X: begin
              mreq.start <= 1'b1;
              mreq.a <= pitch_pass ? 32'(pitch_mag) : 32'(yaw_r);
              mreq.b <= DEG_Q32;
              step   <= SS_XW;
            end
            SS_XW: if (mrsp.done) begin
              xr <= 32'((mrsp.prod + 64'(1 << (ANGLE_FRAC_BITS + 1)))
                        >> (ANGLE_FRAC_BITS + 2));
              step <= SS_X2;
            end
            SS_X2: begin
              mreq.start <= 1'b1; mreq.a <= xr; mreq.b <= xr; step <= SS_X2W;
            end
            SS_X2W: if (mrsp.done) begin
              x2 <= rnd30(mrsp.prod);
              cos_pass <= 1'b0; k <= 3'd1;
              term <= xr; sum <= 34'(xr);
              step <= SS_TM;
            end
            SS_TM: begin
              mreq.start <= 1'b1; mreq.a <= term; mreq.b <= x2; step <= SS_TMW;
            end
            SS_TMW: if (mrsp.done) begin
              dstart <= 1'b1;
              ddend  <= rnd30(mrsp.prod);
              ddsr   <= taylor_div(cos_pass, k);
              step   <= SS_DVW;
            end
            SS_DVW: if (ddone) begin
              term <= dquo;
              if (k[0]) sum <= sum - 34'(dquo);
              else      sum <= sum + 34'(dquo);
              if (k == (cos_pass ? 3'd7 : 3'd6)) begin
                if (!cos_pass) begin
                  s_res <= clamp_unit(k[0] ? sum - 34'(dquo) : sum + 34'(dquo));
                  cos_pass <= 1'b1; k <= 3'd1;
                  term <= ONE_Q30; sum <= 34'(ONE_Q30);
                  step <= SS_TM;
                end else begin
                  // cosine done: map to the angle being worked on
                  step <= SS_X;
                  if (!pitch_pass) begin
                    case (yaw_q)
                      2'd0: begin sy <= s_res; cy <= clamp_unit(sum - 34'(dquo)); end
                      2'd1: begin sy <= clamp_unit(sum - 34'(dquo)); cy <= -s_res; end
                      2'd2: begin sy <= -s_res; cy <= -clamp_unit(sum - 34'(dquo)); end
                      default: begin sy <= -clamp_unit(sum - 34'(dquo)); cy <= s_res; end
                    endcase
                    pitch_pass <= 1'b1;
                  end else begin
                    sp <= pitch_angle[14] ? -s_res : s_res;
                    cp <= clamp_unit(sum - 34'(dquo));
                    pneg <= 1'b0;
                  end
                end
              end else begin
                k <= k + 3'd1;
                step <= SS_TM;
              end
            end
            default: step <= SS_X;
          endcase
        end
        ST_BASIS: begin
          case (step)
            SS_X: begin
              mreq.start <= 1'b1;
              mreq.a <= 32'(opa[33] ? -opa : opa);
              mreq.b <= 32'(opb[33] ? -opb : opb);
              pneg   <= opa[33] ^ opb[33];
              step   <= SS_XW;
            end
            SS_XW: if (mrsp.done) begin
              step <= SS_X;
              case (bidx)
                4'd0: bv[0] <= to_vec(pneg ? -34'(rnd30(mrsp.prod)) : 34'(rnd30(mrsp.prod)));
                4'd1: bv[2] <= to_vec(pneg ? -34'(rnd30(mrsp.prod)) : 34'(rnd30(mrsp.prod)));
                4'd2: bv[6] <= to_vec(pneg ? 34'(rnd30(mrsp.prod)) : -34'(rnd30(mrsp.prod)));
                default: bv[8] <= to_vec(pneg ? 34'(rnd30(mrsp.prod)) : -34'(rnd30(mrsp.prod)));
              endcase
              if (bidx == 4'd3) begin
                bv[1] <= to_vec(sp);
                bv[3] <= to_vec(-sy);
                bv[4] <= '0;
                bv[5] <= to_vec(cy);
                bv[7] <= to_vec(cp);
              end
              bidx <= bidx + 4'd1;
            end
            default: step <= SS_X;
          endcase
        end
        ST_MOVE: begin
          case (step)
            SS_XW: if (mrsp.done) begin
              dmove <= mrsp.prod[31:0];
              if (dir < 3'd6) step <= SS_X;
            end
            SS_X: begin
              mreq.start <= 1'b1;
              mreq.a <= 32'(mv_mag);
              mreq.b <= dmove;
              step   <= SS_X2W;
            end
            SS_X2W: if (mrsp.done) begin
              if (mv_np > 35'sh7FFF_FFFF)       pos[comp] <= 32'sh7FFF_FFFF;
              else if (mv_np < -35'sh8000_0000) pos[comp] <= 32'sh8000_0000;
              else                              pos[comp] <= mv_np[31:0];
              if (comp != 2'd2) begin
                comp <= comp + 2'd1;
                step <= SS_X;
              end
            end
            default: step <= SS_X;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== tb/euler_fly_camera_update_core_tb.sv =====
// Self-checking testbench for euler_fly_camera_update_core: turn and move transfers
// checked against an in-bench fixed-point camera predictor. Depends on efc_pkg and the
// core RTL.
module euler_fly_camera_update_core_tb;
  import efc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int     PHASE_ITEMS = 200;

  typedef struct {
    logic              op;
    logic signed [15:0] yaw_d;
    logic signed [15:0] pitch_d;
    logic [2:0]         dir;
    logic [15:0]        ftime;
  } cam_cmd_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [15:0] vec [9];
  } cam_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_TURN;
  logic signed [15:0] yaw_delta = '0;
  logic signed [15:0] pitch_delta = '0;
  logic [2:0] move_dir = '0;
  logic [15:0] frame_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] front_x, front_y, front_z;
  logic signed [15:0] right_x, right_y, right_z;
  logic signed [15:0] up_x, up_y, up_z;

  // Stimulus queue, the item currently on the bus, and the views still owed.
  cam_cmd_t  pending_cmds [$];
  cam_cmd_t  cmd_on_bus;
  cam_view_t owed_views [$];

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  mismatches = 0;
  longint cycles = 0;

  // Predictor state: speed at the block's width, the rest in wider integers.
  logic [15:0] speed_q;
  int          yaw_q;
  int          pitch_q;
  longint      pos_q [3];
  longint      basis_q [9];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  euler_fly_camera_update_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .yaw_delta(yaw_delta), .pitch_delta(pitch_delta), .move_dir(move_dir),
    .frame_time(frame_time), .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .front_x(front_x), .front_y(front_y), .front_z(front_z),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z)
  );

  // Round to nearest, ties up, on an unsigned magnitude.
  function automatic longint unsigned rnd_shr(longint unsigned m, int s);
    if (s == 0) return m;
    return (m + (64'd1 << (s - 1))) >> s;
  endfunction

  // Round to nearest with ties away from zero.
  function automatic longint srnd_shr(longint v, int s);
    if (v < 0) return -longint'(rnd_shr(longint'(-v), s));
    return longint'(rnd_shr(v, s));
  endfunction

  function automatic longint mul_fix30(longint a, longint b);
    longint unsigned ma, mb;
    longint m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = longint'(rnd_shr(ma * mb, 30));
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint clamp_fix30(longint v);
    if (v < 0) return 0;
    if (v > longint'(ONE_Q30)) return longint'(ONE_Q30);
    return v;
  endfunction

  // Sine and cosine of an angle within the first quadrant, Taylor series at Q30.
  function automatic void quarter_sin_cos(input int r, output longint s, output longint c);
    longint unsigned x, x2, term;
    longint acc;
    x = rnd_shr(longint'(r) * longint'(DEG_Q32), ANGLE_FRAC_BITS + 2);
    x2 = rnd_shr(x * x, 30);
    term = x;
    acc = x;
    for (int k = 1; k <= 6; k++) begin
      term = rnd_shr(term * x2, 30) / ((2 * k) * (2 * k + 1));
      acc = (k & 1) ? acc - longint'(term) : acc + longint'(term);
    end
    s = clamp_fix30(acc);
    term = ONE_Q30;
    acc = ONE_Q30;
    for (int k = 1; k <= 7; k++) begin
      term = rnd_shr(term * x2, 30) / ((2 * k - 1) * (2 * k));
      acc = (k & 1) ? acc - longint'(term) : acc + longint'(term);
    end
    c = clamp_fix30(acc);
  endfunction

  function automatic void rebuild_basis();
    longint s, c, sy, cy, sp, cp;
    int quad, rem;
    quad = yaw_q / int'(QUARTER);
    rem  = yaw_q % int'(QUARTER);
    quarter_sin_cos(rem, s, c);
    case (quad & 3)
      0:       begin sy = s;  cy = c;  end
      1:       begin sy = c;  cy = -s; end
      2:       begin sy = -s; cy = -c; end
      default: begin sy = -c; cy = s;  end
    endcase
    quarter_sin_cos((pitch_q < 0) ? -pitch_q : pitch_q, s, c);
    sp = (pitch_q < 0) ? -s : s;
    cp = c;
    basis_q[0] = srnd_shr(mul_fix30(cy, cp), VEC_SHIFT);
    basis_q[1] = srnd_shr(sp, VEC_SHIFT);
    basis_q[2] = srnd_shr(mul_fix30(sy, cp), VEC_SHIFT);
    basis_q[3] = srnd_shr(-sy, VEC_SHIFT);
    basis_q[4] = 0;
    basis_q[5] = srnd_shr(cy, VEC_SHIFT);
    basis_q[6] = srnd_shr(-mul_fix30(cy, sp), VEC_SHIFT);
    basis_q[7] = srnd_shr(cp, VEC_SHIFT);
    basis_q[8] = srnd_shr(-mul_fix30(sy, sp), VEC_SHIFT);
  endfunction

  task automatic camera_reset();
    speed_q = SPEED_RESET;
    yaw_q   = int'(YAW_RESET);
    pitch_q = 0;
    foreach (pos_q[i]) pos_q[i] = 0;
    foreach (basis_q[i]) basis_q[i] = 0;
    basis_q[2] = -(64'sd1 <<< VEC_FRAC_BITS);
    basis_q[3] = 64'sd1 <<< VEC_FRAC_BITS;
    basis_q[7] = 64'sd1 <<< VEC_FRAC_BITS;
  endtask

  // Advance the camera by one command and return the view it produces.
  function automatic cam_view_t camera_step(cam_cmd_t cmd);
    cam_view_t v;
    int y, p;
    longint unsigned travel, mag;
    longint comp, stride, np;
    bit neg, flip;
    int base;
    if (cmd.op == OP_TURN) begin
      y = yaw_q + int'(cmd.yaw_d);
      p = pitch_q + int'(cmd.pitch_d);
      y = y % int'(FULL_TURN);
      if (y < 0) y += int'(FULL_TURN);
      if (p > int'(PITCH_LIM)) p = int'(PITCH_LIM);
      if (p < -int'(PITCH_LIM)) p = -int'(PITCH_LIM);
      yaw_q = y;
      pitch_q = p;
      rebuild_basis();
    end else if (cmd.dir < 3'd6) begin
      travel = longint'(speed_q) * longint'(cmd.ftime);
      base = (cmd.dir >> 1) * 3;
      flip = (cmd.dir == 3'd1 || cmd.dir == 3'd2 || cmd.dir == 3'd5);
      for (int i = 0; i < 3; i++) begin
        comp = basis_q[base + i];
        neg = (comp < 0) != flip;
        mag = ((comp < 0) ? -comp : comp) * travel;
        stride = longint'(rnd_shr(mag, MOVE_SHIFT));
        np = pos_q[i] + (neg ? -stride : stride);
        if (np > 64'sd2147483647) np = 64'sd2147483647;
        if (np < -64'sd2147483648) np = -64'sd2147483648;
        pos_q[i] = np;
      end
    end
    foreach (v.pos[i]) v.pos[i] = pos_q[i][31:0];
    foreach (v.vec[i]) v.vec[i] = basis_q[i][15:0];
    return v;
  endfunction

  // Driver: present queued commands, idling at random, and predict on every transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) owed_views.push_back(camera_step(cmd_on_bus));
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus  = pending_cmds.pop_front();
          in_valid    <= 1'b1;
          operation   <= cmd_on_bus.op;
          yaw_delta   <= cmd_on_bus.yaw_d;
          pitch_delta <= cmd_on_bus.pitch_d;
          move_dir    <= cmd_on_bus.dir;
          frame_time  <= cmd_on_bus.ftime;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and compare each result transfer with the oldest view owed.
  always @(posedge clk) begin
    cam_view_t want;
    logic signed [31:0] got_pos [3];
    logic signed [15:0] got_vec [9];
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("euler_fly_camera_update_core_tb failed");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        got_pos = '{pos_x, pos_y, pos_z};
        got_vec = '{front_x, front_y, front_z, right_x, right_y, right_z, up_x, up_y, up_z};
        if (owed_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          want = owed_views.pop_front();
          for (int i = 0; i < 3; i++)
            if (got_pos[i] !== want.pos[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("pos[%0d] mismatch: expected %0d, got %0d", i, want.pos[i],
                         got_pos[i]);
            end
          for (int i = 0; i < 9; i++)
            if (got_vec[i] !== want.vec[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("basis[%0d] mismatch: expected %0d, got %0d", i, want.vec[i],
                         got_vec[i]);
            end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic cam_cmd_t make_cmd(logic op, int yd, int pd, int dir, int ft);
    cam_cmd_t c;
    c.op = op;
    c.yaw_d = 16'(yd);
    c.pitch_d = 16'(pd);
    c.dir = 3'(dir);
    c.ftime = 16'(ft);
    return c;
  endfunction

  // Mostly moves, a third of them with full frame times so positions can reach saturation;
  // turns carry either small or full-range deltas.
  function automatic cam_cmd_t random_cmd();
    cam_cmd_t c;
    c.op = ($urandom_range(99) < 30) ? OP_TURN : OP_MOVE;
    c.yaw_d = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(2048)) - 16'sd1024;
    c.pitch_d = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(4096)) - 16'sd2048;
    c.dir = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    c.ftime = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
    return c;
  endfunction

  // Hold the sender until everything owed has arrived.
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || owed_views.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_speed(logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    speed_q = value;
  endtask

  initial begin
    int idle_modes [4];
    int stall_modes [4];
    logic [15:0] speeds [4];
    idle_modes = '{0, 82, 0, 36};
    stall_modes = '{0, 0, 82, 36};
    speeds = '{16'd1, 16'hFFFF, 16'd0, 16'h0000};
    camera_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme deltas, pitch clamp both ways, yaw wrap both ways,
    // every direction including none, zero and full frame time.
    pending_cmds.push_back(make_cmd(OP_TURN, 0, 0, 7, 65535));
    pending_cmds.push_back(make_cmd(OP_TURN, 32767, 32767, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TURN, -32768, -32768, 5, 1));
    pending_cmds.push_back(make_cmd(OP_TURN, 11520, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TURN, -11520, 11392, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TURN, 1, 1, 0, 0));
    for (int d = 0; d < 8; d++) pending_cmds.push_back(make_cmd(OP_MOVE, 32767, -32768, d, 65535));
    pending_cmds.push_back(make_cmd(OP_MOVE, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TURN, 5760, -5000, 0, 0));
    for (int d = 0; d < 6; d++) pending_cmds.push_back(make_cmd(OP_MOVE, 0, 0, d, 40000));
    drain();

    speeds[3] = 16'($urandom_range(65535));
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_modes[ph];
      stall_pct = stall_modes[ph];
      write_speed(speeds[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_cmds.push_back(random_cmd());
      drain();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && owed_views.size() == 0) begin
      $display("euler_fly_camera_update_core_tb passed");
    end else begin
      $display("euler_fly_camera_update_core_tb failed");
    end
    $finish;
  end

endmodule
